### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the glyph row renderer.
// Needs nothing else; each macro expects a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/grr_pkg.sv
// Shared types and constants of the glyph row renderer.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package grr_pkg;

	localparam int ROW_W           = 16;
	localparam int DEF_MAX_GLYPH_W = 16;
	localparam int DEF_MAX_GLYPH_H = 16;
	localparam int QUEUE_DEPTH     = 2;
	localparam int IN_TDATA_W      = 64;
	localparam int OUT_TDATA_W     = 40;
	localparam int CFG_DATA_W      = 16;
	localparam int CFG_INDEX_W     = 3;

	localparam logic [ROW_W-1:0] ROW_MSB = 16'h8000;

	// draw_mode codes
	localparam logic [1:0] MODE_NORMAL  = 2'd0;
	localparam logic [1:0] MODE_MULTI   = 2'd1;
	localparam logic [1:0] MODE_OUTLINE = 2'd2;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_GLYPH_WIDTH  = 3'd0,
		CFG_GLYPH_HEIGHT = 3'd1,
		CFG_LINE_PITCH   = 3'd2,
		CFG_FILL_BG      = 3'd3,
		CFG_BG_COLOR     = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [4:0]  glyph_width;
		logic [4:0]  glyph_height;
		logic [12:0] line_pitch;
		logic        fill_background;
		logic [15:0] background_color;
	} cfg_t;

	// input request as packed in tdata, lowest field last
	typedef struct packed {
		logic [5:0]       pad;
		logic [1:0]       draw_mode;
		logic [15:0]      pen_color;
		logic [11:0]      start_y;
		logic [11:0]      start_x;
		logic [ROW_W-1:0] row_bits;
	} in_item_t;

	// output request as packed in tdata
	typedef struct packed {
		logic [15:0] pixel_color;
		logic [23:0] pixel_addr;
	} out_item_t;

	// one step of work for the pixel walker: up to two rows on adjacent lines
	typedef struct packed {
		logic [ROW_W-1:0] bits1;
		logic [ROW_W-1:0] emit1;
		logic [ROW_W-1:0] bits2;
		logic [ROW_W-1:0] emit2;
		logic [23:0]      base;
		logic [11:0]      x;
		logic [15:0]      color;
	} entry_t;

endpackage

`default_nettype wire

### hw/rtl/glyph_row_renderer_core.sv
// Top level of the glyph row renderer: configuration registers and the
// front end, job queue and pixel walker. Depends on grr_pkg and the grr_ modules.
//
// Each accepted glyph row turns into pixel write requests, one per cycle on
// the master port while it is ready: a row that writes k pixels gives k requests
// (up to 16, or up to 32 on the closing row of an outline glyph, which also
// writes the row above it), and a row that writes nothing gives none.
// The pixel walker in the back end sets the output pace; the front end takes a
// new row every cycle while the two-entry job queue has room, so input and
// output stall independently. After the block has gone idle, a row that is taken
// passes the job queue, the walker's job registers and the output register
// before its first pixel request shows. There is no clearing pass after reset.
`default_nettype none

module glyph_row_renderer_core import grr_pkg::*; #(
	parameter int MAX_GLYPH_W = DEF_MAX_GLYPH_W,
	parameter int MAX_GLYPH_H = DEF_MAX_GLYPH_H
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// fields from bit 0: row_bits[15:0], start_x[27:16], start_y[39:28],
	// pen_color[55:40], draw_mode[57:56], zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// fields from bit 0: pixel_addr[23:0], pixel_color[39:24]
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic                        m_axis_tlast,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t      cfg_q;
	in_item_t  in_item;
	out_item_t out_item;
	entry_t    push_entry;
	entry_t    head;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_empty;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_width      <= 5'd16;
			cfg_q.glyph_height     <= 5'd16;
			cfg_q.line_pitch       <= 13'd640;
			cfg_q.fill_background  <= 1'b0;
			cfg_q.background_color <= 16'd0;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_GLYPH_WIDTH:  cfg_q.glyph_width      <= cfg_data[4:0];
				CFG_GLYPH_HEIGHT: cfg_q.glyph_height     <= cfg_data[4:0];
				CFG_LINE_PITCH:   cfg_q.line_pitch       <= cfg_data[12:0];
				CFG_FILL_BG:      cfg_q.fill_background  <= cfg_data[0];
				CFG_BG_COLOR:     cfg_q.background_color <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_item      = in_item_t'(s_axis_tdata);
	assign m_axis_tdata = out_item;

	grr_front #(
		.MAX_GLYPH_W (MAX_GLYPH_W),
		.MAX_GLYPH_H (MAX_GLYPH_H)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_item    (in_item),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	grr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.pop      (pop),
		.rd_entry (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	grr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (out_item),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire

### hw/rtl/grr_queue.sv
// Short FIFO of row jobs between the front and the pixel walker.
// Depends on grr_pkg for entry_t and the queue depth.
`default_nettype none

module grr_queue import grr_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  entry_t      wr_entry,
	input  wire logic   pop,
	output entry_t      rd_entry,
	output logic        full,
	output logic        empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/grr_front.sv
// Row front end: takes input rows, tracks glyph state, builds row jobs.
// Depends on grr_pkg; feeds grr_queue.
`default_nettype none

module grr_front import grr_pkg::*; #(
	parameter int MAX_GLYPH_W = DEF_MAX_GLYPH_W,
	parameter int MAX_GLYPH_H = DEF_MAX_GLYPH_H
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  cfg_t      cfg,
	input  wire logic in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	input  wire logic q_full,
	output logic      push,
	output entry_t    push_entry
);

	localparam int RC_W = $clog2(MAX_GLYPH_H);
	localparam int WMAX = (MAX_GLYPH_W < ROW_W) ? MAX_GLYPH_W : ROW_W;

	function automatic logic [ROW_W-1:0] outline_of(
		input logic [ROW_W-1:0] above,
		input logic [ROW_W-1:0] mid,
		input logic [ROW_W-1:0] below,
		input logic [ROW_W-1:0] mask
	);
		logic [ROW_W-1:0] grown;
		grown = (mid | (mid << 1) | (mid >> 1) | above | below) & mask;
		return (grown ^ mid) & mask;
	endfunction

	logic [RC_W-1:0]  rc_q;
	logic [ROW_W-1:0] prev_q;
	logic [ROW_W-1:0] held_q;
	logic [11:0]      origin_x_q;
	logic [11:0]      origin_y_q;
	logic [15:0]      run_color_q;
	logic [1:0]       mode_q;

	logic             accept;
	logic             first;
	logic [4:0]       w_eff;
	logic [5:0]       h_eff;
	logic [ROW_W-1:0] mask;
	logic [ROW_W-1:0] cur;
	logic             is_last;
	logic [11:0]      ox;
	logic [11:0]      oy;
	logic [15:0]      run;
	logic [1:0]       mode;
	logic [ROW_W-1:0] prv;
	logic [ROW_W-1:0] hld;
	logic             outline;
	logic [ROW_W-1:0] rowa;
	logic [ROW_W-1:0] rowb;
	logic [ROW_W-1:0] emita;
	logic [ROW_W-1:0] emitb;
	logic [RC_W-1:0]  linea;
	logic [RC_W-1:0]  line;
	logic [12:0]      y;
	logic [25:0]      prod;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign first    = (rc_q == '0);

	// effective width and height
	always_comb begin
		w_eff = cfg.glyph_width;
		if (w_eff == 5'd0) begin
			w_eff = 5'd1;
		end
		if (w_eff > 5'(WMAX)) begin
			w_eff = 5'(WMAX);
		end
		h_eff = {1'b0, cfg.glyph_height};
		if (h_eff == 6'd0) begin
			h_eff = 6'd1;
		end
		if (h_eff > 6'(MAX_GLYPH_H)) begin
			h_eff = 6'(MAX_GLYPH_H);
		end
	end

	assign mask    = ~(16'hFFFF >> w_eff);
	assign cur     = in_item.row_bits & mask;
	assign is_last = (6'(rc_q) >= (h_eff - 6'd1));

	// per-glyph values, taken from the request on the first row
	assign ox      = first ? in_item.start_x   : origin_x_q;
	assign oy      = first ? in_item.start_y   : origin_y_q;
	assign run     = first ? in_item.pen_color : run_color_q;
	assign mode    = first ? in_item.draw_mode : mode_q;
	assign prv     = first ? '0 : prev_q;
	assign hld     = first ? '0 : held_q;
	assign outline = (mode == MODE_OUTLINE);

	// rows to draw: outline draws the row above one step late
	always_comb begin
		rowa  = outline ? outline_of(prv, hld, cur, mask) : cur;
		rowb  = outline_of(hld, cur, '0, mask);
		linea = outline ? rc_q - 1'b1 : rc_q;
		if (!outline || (rc_q != '0)) begin
			emita = cfg.fill_background ? mask : rowa;
		end else begin
			emita = '0;
		end
		if (outline && is_last) begin
			emitb = cfg.fill_background ? mask : rowb;
		end else begin
			emitb = '0;
		end
	end

	// pack the job so that its first row always writes something
	always_comb begin
		if (emita != '0) begin
			push_entry.bits1 = rowa;
			push_entry.emit1 = emita;
			push_entry.bits2 = rowb;
			push_entry.emit2 = emitb;
			line             = linea;
		end else begin
			push_entry.bits1 = rowb;
			push_entry.emit1 = emitb;
			push_entry.bits2 = '0;
			push_entry.emit2 = '0;
			line             = rc_q;
		end
		y                = {1'b0, oy} + 13'(line);
		prod             = 26'(y) * 26'(cfg.line_pitch);
		push_entry.base  = prod[23:0];
		push_entry.x     = ox;
		push_entry.color = run;
	end

	assign push = accept && (push_entry.emit1 != '0);

	// glyph state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q        <= '0;
			prev_q      <= '0;
			held_q      <= '0;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			run_color_q <= '0;
			mode_q      <= MODE_NORMAL;
		end else if (accept) begin
			rc_q        <= is_last ? '0 : rc_q + 1'b1;
			prev_q      <= hld;
			held_q      <= cur;
			origin_x_q  <= ox;
			origin_y_q  <= oy;
			run_color_q <= (mode == MODE_MULTI) ? run + 16'd1 : run;
			mode_q      <= mode;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/grr_back.sv
// Pixel walker: takes row jobs from the queue and writes one pixel per cycle while the output is ready.
// Depends on grr_pkg; fed by grr_queue.
`default_nettype none

module grr_back import grr_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  cfg_t        cfg,
	input  wire logic   q_empty,
	input  entry_t      head,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_ready,
	output out_item_t   out_item,
	output logic        out_last
);

	logic             act_q;
	logic [ROW_W-1:0] bits_q;
	logic [ROW_W-1:0] emit_q;
	logic [ROW_W-1:0] bits2_q;
	logic [ROW_W-1:0] emit2_q;
	logic [23:0]      base_q;
	logic [11:0]      x_q;
	logic [15:0]      color_q;
	logic             out_valid_q;
	out_item_t        out_item_q;
	logic             out_last_q;

	logic             adv;
	logic [3:0]       j_sel;
	logic             found;
	logic [ROW_W-1:0] sel;
	logic [ROW_W-1:0] clr;
	logic             row_done;
	logic             step_done;
	logic             load;

	// leftmost pixel still to write
	always_comb begin
		found = 1'b0;
		j_sel = '0;
		for (int j = 0; j < ROW_W; j++) begin
			if (!found && emit_q[ROW_W-1-j]) begin
				found = 1'b1;
				j_sel = 4'(j);
			end
		end
	end

	assign sel       = ROW_MSB >> j_sel;
	assign clr       = emit_q & ~sel;
	assign row_done  = (clr == '0);
	assign step_done = row_done && (emit2_q == '0);
	assign adv       = !out_valid_q || out_ready;
	assign load      = adv && (!act_q || step_done) && !q_empty;
	assign pop       = load;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign out_last  = out_last_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= act_q;
			if (load) begin
				act_q <= 1'b1;
			end else if (step_done) begin
				act_q <= 1'b0;
			end
		end
	end

	// job registers and output request
	always_ff @(posedge clk) begin
		if (adv) begin
			if (act_q) begin
				out_item_q.pixel_addr  <= base_q + 24'(x_q) + 24'(j_sel);
				out_item_q.pixel_color <= ((bits_q & sel) != '0) ? color_q
				                                                 : cfg.background_color;
				out_last_q             <= step_done;
			end
			if (load) begin
				bits_q  <= head.bits1;
				emit_q  <= head.emit1;
				bits2_q <= head.bits2;
				emit2_q <= head.emit2;
				base_q  <= head.base;
				x_q     <= head.x;
				color_q <= head.color;
			end else if (act_q && row_done) begin
				// move on to the next line of the job
				bits_q  <= bits2_q;
				emit_q  <= emit2_q;
				emit2_q <= '0;
				base_q  <= base_q + 24'(cfg.line_pitch);
			end else if (act_q) begin
				emit_q <= clr;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/grr_checker.sv
// Port-level checks of the glyph row renderer, bound to the top level.
// Depends on grr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module grr_checker import grr_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_axis_tvalid,
	input wire logic                   s_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic                   m_axis_tlast
);

	// a stalled output request holds its contents
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled pixel request changed")

	// the queue only fills up by taking a request
	`ASSERT_IMPLIES(a_ready_fall, clk, arst_n, $fell(s_axis_tready), $past(s_axis_tvalid && s_axis_tready), "input ready dropped without an accepted row")

	// pixels of one row arrive without gaps
	`ASSERT_NEXT(a_no_gap, clk, arst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "gap inside the pixels of one row")

endmodule

bind glyph_row_renderer_core grr_checker u_grr_checker (.*);

`default_nettype wire
